>>> rtl/tdcg_pkg.sv
// Shared types, constants and helper functions of the drive command gate.
package tdcg_pkg;

   localparam int STICK_BITS_DEFAULT = 16;
   localparam int EXPO_DEPTH_DEFAULT = 256;

   // request kinds
   localparam logic [1:0] OP_STICK  = 2'd0;
   localparam logic [1:0] OP_BUTTON = 2'd1;
   localparam logic [1:0] OP_ENABLE = 2'd2;
   localparam logic [1:0] OP_TICK   = 2'd3;

   // register indexes, byte address 4*index
   localparam logic [2:0] REG_THROTTLE_GAIN = 3'd0;
   localparam logic [2:0] REG_BRAKE_GAIN    = 3'd1;
   localparam logic [2:0] REG_STEER_GAIN    = 3'd2;
   localparam logic [2:0] REG_IDLE_BRAKE    = 3'd3;
   localparam logic [2:0] REG_MAX_STEER     = 3'd4;
   localparam logic [2:0] REG_EXPO_SENS     = 3'd5;
   localparam logic [2:0] REG_POS_SPAN      = 3'd6;
   localparam logic [2:0] REG_NEG_SPAN      = 3'd7;

   // reset values
   localparam logic [15:0] GAIN_RESET       = 16'd256;
   localparam logic [23:0] IDLE_BRAKE_RESET = 24'hFF8800;
   localparam logic [22:0] MAX_STEER_RESET  = 23'd92160;
   localparam logic [15:0] EXPO_SENS_RESET  = 16'd4096;
   localparam logic [15:0] POS_SPAN_RESET   = 16'd32768;
   localparam logic [15:0] NEG_SPAN_RESET   = 16'd27853;

   // sensitivity used when the register holds zero (about 0.001 in Q4.12)
   localparam logic [15:0] MIN_SENS = 16'd4;

   // configuration seen by the stick shaper
   typedef struct packed {
      logic [15:0] throttle_gain;
      logic [15:0] brake_gain;
      logic [15:0] steer_gain;
      logic [15:0] expo_sensitivity;
      logic [15:0] pos_stick_span;
      logic [15:0] neg_stick_span;
   } cfg_type;

   // shaped stick sample
   typedef struct packed {
      logic [23:0] throttle;
      logic [23:0] brake;
      logic [23:0] steer;
   } shape_result_type;

   // command word for the shared multiply-accumulate and divide unit
   typedef struct packed {
      logic        mul_en;
      logic        mul_acc;
      logic        mul_high;
      logic [31:0] mul_a;
      logic [31:0] mul_b;
      logic        div_start;
      logic [63:0] div_dividend;
      logic [63:0] div_divisor;
      logic [6:0]  div_bits;
   } alu_cmd_type;

   // round(e^n * 2^16)
   function automatic logic [37:0] exp_int_q16(input logic [3:0] n);
      logic [37:0] e;
      case (n)
         4'd0:    e = 38'd65536;
         4'd1:    e = 38'd178145;
         4'd2:    e = 38'd484249;
         4'd3:    e = 38'd1316326;
         4'd4:    e = 38'd3578144;
         4'd5:    e = 38'd9726405;
         4'd6:    e = 38'd26439109;
         4'd7:    e = 38'd71868951;
         4'd8:    e = 38'd195360063;
         4'd9:    e = 38'd531043708;
         4'd10:   e = 38'd1443526462;
         4'd11:   e = 38'd3923911752;
         4'd12:   e = 38'd10666298010;
         4'd13:   e = 38'd28994004059;
         4'd14:   e = 38'd78813874367;
         default: e = 38'd214238322522;
      endcase
      return e;
   endfunction

   // apply a sign to a magnitude and saturate to 24-bit two's complement
   function automatic logic [23:0] sat_signed(input logic [63:0] mag, input logic neg);
      logic [23:0] r;
      if (neg) begin
         if (mag > 64'd8388608) r = 24'h800000;
         else r = (~mag[23:0]) + 24'd1;
      end else begin
         if (mag > 64'd8388607) r = 24'h7FFFFF;
         else r = mag[23:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/teleop_drive_command_gate_unit.sv
// Top level of the drive command gate: registers, held state, request and result channels.
// Button, enable and tick requests are handled at acceptance; a tick result appears the cycle after.
// A stick request runs two expm1 evaluations, three when the curve is interpolated, each of
// 20 terms with a 32-bit divide per term after the first, plus 28- and 64-bit divides.
// One request at a time; ready returns once the shaper is idle and no tick result waits.
// Synchronous active-high reset restores register defaults and clears all held state.
module teleop_drive_command_gate_unit #(
   parameter int STICK_BITS       = tdcg_pkg::STICK_BITS_DEFAULT,
   parameter int EXPO_TABLE_DEPTH = tdcg_pkg::EXPO_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_op,
   input  logic signed [STICK_BITS-1:0] req_stick_linear,
   input  logic signed [STICK_BITS-1:0] req_stick_steer,
   input  logic                         req_reverse_button,
   input  logic                         req_deadman_button,
   input  logic                         req_left_button,
   input  logic                         req_right_button,
   input  logic                         req_enable_in,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [23:0]           rsp_throttle_cmd,
   output logic signed [23:0]           rsp_brake_cmd,
   output logic signed [23:0]           rsp_steer_cmd,
   output logic                         rsp_reverse_cmd,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [4:0]                   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   logic [15:0] throttle_gain_ff, brake_gain_ff, steer_gain_ff;
   logic [23:0] idle_brake_ff;
   logic [22:0] max_steer_ff;
   logic [15:0] expo_sens_ff, pos_span_ff, neg_span_ff;

   logic [23:0] held_throttle_ff, held_throttle_in;
   logic [23:0] held_brake_ff, held_brake_in;
   logic [23:0] held_steer_ff, held_steer_in;
   logic        held_reverse_ff, held_reverse_in;
   logic        held_deadman_ff, held_deadman_in;
   logic        held_left_ff, held_left_in;
   logic        held_right_ff, held_right_in;
   logic        enabled_ff, enabled_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_thr_ff, rsp_thr_in;
   logic [23:0] rsp_brk_ff, rsp_brk_in;
   logic [23:0] rsp_str_ff, rsp_str_in;
   logic        rsp_rev_ff, rsp_rev_in;

   logic        accept;
   logic        cfg_write;
   logic [2:0]  cfg_index;
   logic        core_idle;
   logic        core_done;
   logic [23:0] steer_eff;

   tdcg_pkg::cfg_type          core_cfg;
   tdcg_pkg::shape_result_type core_result;

   assign accept    = req_valid && req_ready;
   assign req_ready = core_idle && (!rsp_valid_ff || rsp_ready);
   assign cfg_write = csr_psel && csr_penable && csr_pwrite;
   assign cfg_index = csr_paddr[4:2];

   assign core_cfg.throttle_gain    = throttle_gain_ff;
   assign core_cfg.brake_gain       = brake_gain_ff;
   assign core_cfg.steer_gain       = steer_gain_ff;
   assign core_cfg.expo_sensitivity = expo_sens_ff;
   assign core_cfg.pos_stick_span   = pos_span_ff;
   assign core_cfg.neg_stick_span   = neg_span_ff;

   tdcg_shaper #(
      .STICK_BITS       (STICK_BITS),
      .EXPO_TABLE_DEPTH (EXPO_TABLE_DEPTH)
   ) u_shaper (
      .clock        (clock),
      .reset        (reset),
      .start        (accept && (req_op == tdcg_pkg::OP_STICK)),
      .stick_linear (req_stick_linear),
      .stick_steer  (req_stick_steer),
      .cfg          (core_cfg),
      .idle         (core_idle),
      .done         (core_done),
      .result       (core_result)
   );

   // register file writes
   always_ff @(posedge clock) begin
      if (reset) begin
         throttle_gain_ff <= tdcg_pkg::GAIN_RESET;
         brake_gain_ff    <= tdcg_pkg::GAIN_RESET;
         steer_gain_ff    <= tdcg_pkg::GAIN_RESET;
         idle_brake_ff    <= tdcg_pkg::IDLE_BRAKE_RESET;
         max_steer_ff     <= tdcg_pkg::MAX_STEER_RESET;
         expo_sens_ff     <= tdcg_pkg::EXPO_SENS_RESET;
         pos_span_ff      <= tdcg_pkg::POS_SPAN_RESET;
         neg_span_ff      <= tdcg_pkg::NEG_SPAN_RESET;
      end else if (cfg_write) begin
         unique case (cfg_index)
            tdcg_pkg::REG_THROTTLE_GAIN: throttle_gain_ff <= csr_pwdata[15:0];
            tdcg_pkg::REG_BRAKE_GAIN:    brake_gain_ff    <= csr_pwdata[15:0];
            tdcg_pkg::REG_STEER_GAIN:    steer_gain_ff    <= csr_pwdata[15:0];
            tdcg_pkg::REG_IDLE_BRAKE:    idle_brake_ff    <= csr_pwdata[23:0];
            tdcg_pkg::REG_MAX_STEER:     max_steer_ff     <= csr_pwdata[22:0];
            tdcg_pkg::REG_EXPO_SENS:     expo_sens_ff     <= csr_pwdata[15:0];
            tdcg_pkg::REG_POS_SPAN:      pos_span_ff      <= csr_pwdata[15:0];
            tdcg_pkg::REG_NEG_SPAN:      neg_span_ff      <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // register read-back
   always_comb begin
      unique case (cfg_index)
         tdcg_pkg::REG_THROTTLE_GAIN: csr_prdata = {16'd0, throttle_gain_ff};
         tdcg_pkg::REG_BRAKE_GAIN:    csr_prdata = {16'd0, brake_gain_ff};
         tdcg_pkg::REG_STEER_GAIN:    csr_prdata = {16'd0, steer_gain_ff};
         tdcg_pkg::REG_IDLE_BRAKE:    csr_prdata = {8'd0, idle_brake_ff};
         tdcg_pkg::REG_MAX_STEER:     csr_prdata = {9'd0, max_steer_ff};
         tdcg_pkg::REG_EXPO_SENS:     csr_prdata = {16'd0, expo_sens_ff};
         tdcg_pkg::REG_POS_SPAN:      csr_prdata = {16'd0, pos_span_ff};
         tdcg_pkg::REG_NEG_SPAN:      csr_prdata = {16'd0, neg_span_ff};
         default:                     csr_prdata = 32'd0;
      endcase
   end
   assign csr_pready = 1'b1;

   // held state updates and tick gating
   always_comb begin
      held_throttle_in = held_throttle_ff;
      held_brake_in    = held_brake_ff;
      held_steer_in    = held_steer_ff;
      held_reverse_in  = held_reverse_ff;
      held_deadman_in  = held_deadman_ff;
      held_left_in     = held_left_ff;
      held_right_in    = held_right_ff;
      enabled_in       = enabled_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_thr_in       = rsp_thr_ff;
      rsp_brk_in       = rsp_brk_ff;
      rsp_str_in       = rsp_str_ff;
      rsp_rev_in       = rsp_rev_ff;

      // left and right buttons override the held steering
      if (held_left_ff) steer_eff = (~{1'b0, max_steer_ff}) + 24'd1;
      else if (held_right_ff) steer_eff = {1'b0, max_steer_ff};
      else steer_eff = held_steer_ff;

      if (core_done) begin
         held_throttle_in = core_result.throttle;
         held_brake_in    = core_result.brake;
         held_steer_in    = core_result.steer;
      end

      if (accept) begin
         case (req_op)
            tdcg_pkg::OP_STICK: begin
               held_reverse_in = req_reverse_button;
            end
            tdcg_pkg::OP_BUTTON: begin
               held_deadman_in = req_deadman_button;
               held_left_in    = req_left_button;
               held_right_in   = req_right_button;
            end
            tdcg_pkg::OP_ENABLE: begin
               enabled_in = req_enable_in;
            end
            default: begin
               rsp_valid_in = 1'b1;
               if (!enabled_ff) begin
                  rsp_thr_in = 24'd0;
                  rsp_brk_in = 24'd0;
                  rsp_str_in = 24'd0;
                  rsp_rev_in = 1'b0;
               end else if (!held_deadman_ff) begin
                  rsp_thr_in = 24'd0;
                  rsp_brk_in = idle_brake_ff;
                  rsp_str_in = 24'd0;
                  rsp_rev_in = 1'b0;
               end else begin
                  held_steer_in = steer_eff;
                  rsp_thr_in    = held_throttle_ff;
                  rsp_brk_in    = held_brake_ff;
                  rsp_str_in    = steer_eff;
                  rsp_rev_in    = held_reverse_ff;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_throttle_ff <= 24'd0;
         held_brake_ff    <= 24'd0;
         held_steer_ff    <= 24'd0;
         held_reverse_ff  <= 1'b0;
         held_deadman_ff  <= 1'b0;
         held_left_ff     <= 1'b0;
         held_right_ff    <= 1'b0;
         enabled_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         held_throttle_ff <= held_throttle_in;
         held_brake_ff    <= held_brake_in;
         held_steer_ff    <= held_steer_in;
         held_reverse_ff  <= held_reverse_in;
         held_deadman_ff  <= held_deadman_in;
         held_left_ff     <= held_left_in;
         held_right_ff    <= held_right_in;
         enabled_ff       <= enabled_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      rsp_thr_ff <= rsp_thr_in;
      rsp_brk_ff <= rsp_brk_in;
      rsp_str_ff <= rsp_str_in;
      rsp_rev_ff <= rsp_rev_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_throttle_cmd = rsp_thr_ff;
   assign rsp_brake_cmd    = rsp_brk_ff;
   assign rsp_steer_cmd    = rsp_str_ff;
   assign rsp_reverse_cmd  = rsp_rev_ff;

   // no request is taken while the shaper works on a stick sample
   assert property (@(posedge clock) disable iff (reset) !core_idle |-> !req_ready)
      else $error("request ready while shaper busy");

   // a stick request always starts the shaper
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == tdcg_pkg::OP_STICK) |=> !core_idle)
      else $error("stick request did not start shaper");

   // a new result only follows an accepted tick
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept && req_op == tdcg_pkg::OP_TICK))
      else $error("result without tick request");

   // a tick while disabled yields an all-zero command
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == tdcg_pkg::OP_TICK && !enabled_ff) |=>
      (rsp_thr_ff == 24'd0 && rsp_brk_ff == 24'd0 && rsp_str_ff == 24'd0 && !rsp_rev_ff))
      else $error("disabled tick not zero");

endmodule

>>> rtl/tdcg_alu.sv
// Shared arithmetic unit: 32x32 multiply-accumulate and a radix-2 restoring divider.
module tdcg_alu (
   input  logic                  clock,
   input  logic                  reset,
   input  tdcg_pkg::alu_cmd_type cmd,
   output logic [63:0]           acc,
   output logic [63:0]           quot,
   output logic                  busy
);

   logic [63:0] prod;
   logic [63:0] addend;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] q_ff, q_in;
   logic [63:0] r_ff, r_in;
   logic [63:0] d_ff, d_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [64:0] trial;
   logic        ge;

   // multiply, optionally into the upper word, and accumulate
   always_comb begin
      prod   = {32'd0, cmd.mul_a} * {32'd0, cmd.mul_b};
      addend = cmd.mul_high ? {prod[31:0], 32'd0} : prod;
      acc_in = acc_ff;
      if (cmd.mul_en) begin
         acc_in = (cmd.mul_acc ? acc_ff : 64'd0) + addend;
      end
   end

   // one quotient bit per cycle
   always_comb begin
      trial  = {r_ff, q_ff[63]};
      ge     = trial >= {1'b0, d_ff};
      q_in   = q_ff;
      r_in   = r_ff;
      d_in   = d_ff;
      cnt_in = cnt_ff;
      if (cmd.div_start) begin
         q_in   = cmd.div_dividend << (7'd64 - cmd.div_bits);
         r_in   = 64'd0;
         d_in   = cmd.div_divisor;
         cnt_in = cmd.div_bits;
      end else if (cnt_ff != 7'd0) begin
         r_in   = ge ? 64'(trial - {1'b0, d_ff}) : trial[63:0];
         q_in   = {q_ff[62:0], ge};
         cnt_in = cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 7'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
   end

   assign acc  = acc_ff;
   assign quot = q_ff;
   assign busy = cnt_ff != 7'd0;

endmodule

>>> rtl/tdcg_shaper.sv
// Stick sample sequencer: linear split, steering normalize, expo curve and gain.
module tdcg_shaper #(
   parameter int STICK_BITS       = tdcg_pkg::STICK_BITS_DEFAULT,
   parameter int EXPO_TABLE_DEPTH = tdcg_pkg::EXPO_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [STICK_BITS-1:0]      stick_linear,
   input  logic [STICK_BITS-1:0]      stick_steer,
   input  tdcg_pkg::cfg_type          cfg,
   output logic                       idle,
   output logic                       done,
   output tdcg_pkg::shape_result_type result
);

   localparam int LG     = $clog2(EXPO_TABLE_DEPTH);
   localparam int IW     = LG + 1;
   localparam int PW     = 13 + LG;
   localparam int XSH    = 28 - STICK_BITS;
   localparam int VSH    = 20 - LG;
   localparam int LIN_SH = STICK_BITS - 1;
   localparam logic [63:0] LIN_HALF = 64'd1 << (STICK_BITS - 2);
   localparam logic [IW-1:0] DEPTH_I = IW'(EXPO_TABLE_DEPTH);

   typedef enum logic [4:0] {
      ST_IDLE, ST_LIN_MUL, ST_LIN_WR, ST_X_WAIT, ST_PT_MUL, ST_PT_V,
      ST_E_MUL, ST_E_DIV, ST_E_WAIT, ST_E_FIN, ST_E_FIN_HI, ST_E_DONE,
      ST_RET, ST_NORM, ST_Q_WAIT, ST_IP_LO, ST_IP_HI, ST_IP_ADD,
      ST_G_LO, ST_G_HI, ST_G_WR, ST_DONE
   } state_type;

   typedef enum logic [1:0] {PH_DEN, PH_C0, PH_C1} phase_type;

   state_type             state_ff, state_in;
   phase_type             phase_ff, phase_in;
   logic                  lin_le0_ff, lin_le0_in;
   logic [STICK_BITS-1:0] lin_mag_ff, lin_mag_in;
   logic                  steer_neg_ff, steer_neg_in;
   logic [STICK_BITS-1:0] steer_mag_ff, steer_mag_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic [IW-1:0]         i_ff, i_in;
   logic [11:0]           rem_ff, rem_in;
   logic [31:0]           f_ff, f_in;
   logic [31:0]           term_ff, term_in;
   logic [3:0]            n_ff, n_in;
   logic [63:0]           sum_ff, sum_in;
   logic [4:0]            k_ff, k_in;
   logic [63:0]           ex_ff, ex_in;
   logic [63:0]           den_ff, den_in;
   logic [4:0]            sh_ff, sh_in;
   logic [63:0]           c0_ff, c0_in;
   logic [63:0]           c1_ff, c1_in;
   logic [23:0]           thr_ff, thr_in;
   logic [23:0]           brk_ff, brk_in;
   logic [23:0]           str_ff, str_in;

   tdcg_pkg::alu_cmd_type cmd;
   logic [63:0]           acc;
   logic [63:0]           quot;
   logic                  busy;

   logic [15:0]           s_eff;
   logic [15:0]           span_eff;
   logic [12:0]           x_val;
   logic [PW-1:0]         pos_w;
   logic [63:0]           v_w;
   logic [37:0]           e_val;
   logic [63:0]           num_sh;
   logic [63:0]           diff;
   logic [63:0]           lin_v;
   logic [63:0]           steer_v;

   tdcg_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .acc   (acc),
      .quot  (quot),
      .busy  (busy)
   );

   // derived operands
   always_comb begin
      s_eff    = (cfg.expo_sensitivity == 16'd0) ? tdcg_pkg::MIN_SENS : cfg.expo_sensitivity;
      span_eff = steer_neg_ff ? cfg.neg_stick_span : cfg.pos_stick_span;
      if (span_eff == 16'd0) span_eff = 16'd1;
      x_val    = (quot > 64'd4096) ? 13'd4096 : quot[12:0];
      pos_w    = PW'(x_val) << LG;
      v_w      = acc << VSH;
      e_val    = tdcg_pkg::exp_int_q16(n_ff);
      num_sh   = ex_ff >> sh_ff;
      diff     = c1_ff - c0_ff;
      lin_v    = (acc + LIN_HALF) >> LIN_SH;
      steer_v  = (acc + 64'd2048) >> 12;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      lin_le0_in   = lin_le0_ff;
      lin_mag_in   = lin_mag_ff;
      steer_neg_in = steer_neg_ff;
      steer_mag_in = steer_mag_ff;
      idx_in       = idx_ff;
      i_in         = i_ff;
      rem_in       = rem_ff;
      f_in         = f_ff;
      term_in      = term_ff;
      n_in         = n_ff;
      sum_in       = sum_ff;
      k_in         = k_ff;
      ex_in        = ex_ff;
      den_in       = den_ff;
      sh_in        = sh_ff;
      c0_in        = c0_ff;
      c1_in        = c1_ff;
      thr_in       = thr_ff;
      brk_in       = brk_ff;
      str_in       = str_ff;
      cmd          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               // split linear axis: positive is throttle, the rest is brake
               lin_le0_in   = stick_linear[STICK_BITS-1] || (stick_linear == '0);
               lin_mag_in   = stick_linear[STICK_BITS-1] ? (~stick_linear) + 1'b1
                                                         : stick_linear;
               steer_neg_in = stick_steer[STICK_BITS-1];
               steer_mag_in = stick_steer[STICK_BITS-1] ? (~stick_steer) + 1'b1
                                                        : stick_steer;
               state_in     = ST_LIN_MUL;
            end
         end
         ST_LIN_MUL: begin
            cmd.mul_en = 1'b1;
            cmd.mul_a  = {16'd0, lin_le0_ff ? cfg.brake_gain : cfg.throttle_gain};
            cmd.mul_b  = 32'(lin_mag_ff);
            state_in   = ST_LIN_WR;
         end
         ST_LIN_WR: begin
            if (lin_le0_ff) begin
               thr_in = 24'd0;
               brk_in = tdcg_pkg::sat_signed(lin_v, 1'b1);
            end else begin
               thr_in = tdcg_pkg::sat_signed(lin_v, 1'b0);
               brk_in = 24'd0;
            end
            // normalize steering magnitude to Q0.12 by its side's span
            cmd.div_start    = 1'b1;
            cmd.div_dividend = 64'(steer_mag_ff) << XSH;
            cmd.div_divisor  = {48'd0, span_eff};
            cmd.div_bits     = 7'd28;
            state_in         = ST_X_WAIT;
         end
         ST_X_WAIT: begin
            if (!busy) begin
               idx_in   = pos_w[PW-1:12];
               rem_in   = pos_w[11:0];
               i_in     = DEPTH_I;
               phase_in = PH_DEN;
               state_in = ST_PT_MUL;
            end
         end
         ST_PT_MUL: begin
            cmd.mul_en = 1'b1;
            cmd.mul_a  = {16'd0, s_eff};
            cmd.mul_b  = 32'(i_ff);
            state_in   = ST_PT_V;
         end
         ST_PT_V: begin
            // expm1 argument in Q32: integer part and fraction
            f_in     = v_w[31:0];
            n_in     = v_w[35:32];
            term_in  = v_w[31:0];
            sum_in   = {32'd0, v_w[31:0]};
            k_in     = 5'd2;
            state_in = ST_E_MUL;
         end
         ST_E_MUL: begin
            cmd.mul_en = 1'b1;
            cmd.mul_a  = term_ff;
            cmd.mul_b  = f_ff;
            state_in   = ST_E_DIV;
         end
         ST_E_DIV: begin
            cmd.div_start    = 1'b1;
            cmd.div_dividend = {32'd0, acc[63:32]};
            cmd.div_divisor  = {59'd0, k_ff};
            cmd.div_bits     = 7'd32;
            state_in         = ST_E_WAIT;
         end
         ST_E_WAIT: begin
            if (!busy) begin
               term_in = quot[31:0];
               sum_in  = sum_ff + {32'd0, quot[31:0]};
               if (k_ff == 5'd20) begin
                  state_in = ST_E_FIN;
               end else begin
                  k_in     = k_ff + 5'd1;
                  state_in = ST_E_MUL;
               end
            end
         end
         ST_E_FIN: begin
            if (n_ff == 4'd0) begin
               ex_in    = sum_ff;
               state_in = ST_RET;
            end else begin
               // sum stays below 2^34, so sum>>16 fits 32 bits
               cmd.mul_en = 1'b1;
               cmd.mul_a  = e_val[31:0];
               cmd.mul_b  = sum_ff[47:16];
               state_in   = ST_E_FIN_HI;
            end
         end
         ST_E_FIN_HI: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_acc  = 1'b1;
            cmd.mul_high = 1'b1;
            cmd.mul_a    = {26'd0, e_val[37:32]};
            cmd.mul_b    = sum_ff[47:16];
            state_in     = ST_E_DONE;
         end
         ST_E_DONE: begin
            ex_in    = ((64'(e_val) - 64'd65536) << 16) + (acc >> 16);
            state_in = ST_RET;
         end
         ST_RET: begin
            if (phase_ff == PH_DEN) begin
               den_in   = ex_ff;
               sh_in    = 5'd0;
               state_in = ST_NORM;
            end else if (den_ff == 64'd0) begin
               if (phase_ff == PH_C0) c0_in = 64'd0;
               else c1_in = 64'd0;
               state_in = ST_Q_WAIT;
            end else begin
               // rounded num*4096/den
               cmd.div_start    = 1'b1;
               cmd.div_dividend = (num_sh << 12) + (den_ff >> 1);
               cmd.div_divisor  = den_ff;
               cmd.div_bits     = 7'd64;
               state_in         = ST_Q_WAIT;
            end
         end
         ST_NORM: begin
            // bring the denominator below 2^48 one bit at a time
            if (den_ff[63:48] != 16'd0) begin
               den_in = den_ff >> 1;
               sh_in  = sh_ff + 5'd1;
            end else begin
               i_in     = idx_ff;
               phase_in = PH_C0;
               state_in = ST_PT_MUL;
            end
         end
         ST_Q_WAIT: begin
            if (!busy) begin
               if (phase_ff == PH_C0) begin
                  if (den_ff != 64'd0) c0_in = quot;
                  if (rem_ff != 12'd0) begin
                     i_in     = idx_ff + 1'b1;
                     phase_in = PH_C1;
                     state_in = ST_PT_MUL;
                  end else begin
                     state_in = ST_G_LO;
                  end
               end else begin
                  if (den_ff != 64'd0) c1_in = quot;
                  state_in = ST_IP_LO;
               end
            end
         end
         ST_IP_LO: begin
            cmd.mul_en = 1'b1;
            cmd.mul_a  = diff[31:0];
            cmd.mul_b  = {20'd0, rem_ff};
            state_in   = ST_IP_HI;
         end
         ST_IP_HI: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_acc  = 1'b1;
            cmd.mul_high = 1'b1;
            cmd.mul_a    = diff[63:32];
            cmd.mul_b    = {20'd0, rem_ff};
            state_in     = ST_IP_ADD;
         end
         ST_IP_ADD: begin
            c0_in    = c0_ff + ((acc + 64'd2048) >> 12);
            state_in = ST_G_LO;
         end
         ST_G_LO: begin
            cmd.mul_en = 1'b1;
            cmd.mul_a  = c0_ff[31:0];
            cmd.mul_b  = {16'd0, cfg.steer_gain};
            state_in   = ST_G_HI;
         end
         ST_G_HI: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_acc  = 1'b1;
            cmd.mul_high = 1'b1;
            cmd.mul_a    = c0_ff[63:32];
            cmd.mul_b    = {16'd0, cfg.steer_gain};
            state_in     = ST_G_WR;
         end
         ST_G_WR: begin
            str_in   = tdcg_pkg::sat_signed(steer_v, steer_neg_ff);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_DEN;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
      lin_le0_ff   <= lin_le0_in;
      lin_mag_ff   <= lin_mag_in;
      steer_neg_ff <= steer_neg_in;
      steer_mag_ff <= steer_mag_in;
      idx_ff       <= idx_in;
      i_ff         <= i_in;
      rem_ff       <= rem_in;
      f_ff         <= f_in;
      term_ff      <= term_in;
      n_ff         <= n_in;
      sum_ff       <= sum_in;
      k_ff         <= k_in;
      ex_ff        <= ex_in;
      den_ff       <= den_in;
      sh_ff        <= sh_in;
      c0_ff        <= c0_in;
      c1_ff        <= c1_in;
      thr_ff       <= thr_in;
      brk_ff       <= brk_in;
      str_ff       <= str_in;
   end

   assign idle            = state_ff == ST_IDLE;
   assign done            = state_ff == ST_DONE;
   assign result.throttle = thr_ff;
   assign result.brake    = brk_ff;
   assign result.steer    = str_ff;

endmodule
